// ===== rtl/core/lfa_pkg.sv =====
// Package for the lowest-free identifier allocator: widths, request and
// status codes, controller states and the command/status structs.
// No dependencies; compiled first.
`default_nettype none

package lfa_pkg;

  // Field widths fixed by the request and result formats
  localparam int ID_W   = 32;
  localparam int REQ_W  = 2;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 7;

  // id_count is 7 bits, so no window exceeds this many slots
  localparam int MAX_WIN = 127;

  // Flags examined per scan step
  localparam int LANE_W  = 32;
  localparam int LANE_IW = 5;

  // APB register map
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;
  localparam logic REG_BASE_ID  = 1'b0;
  localparam logic REG_ID_COUNT = 1'b1;

  typedef enum logic [REQ_W-1:0] {
    REQ_ISSUE = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_QUERY = 2'd2
  } req_type_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FAIL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_FREE,
    S_APPLY,
    S_SCAN_MAX,
    S_RESULT
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load_req;
    logic scan_clr;
    logic scan_step;
    logic apply;
    logic load_rsp;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_issue;
    logic scan_last;
    logic rsp_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/lfa_if.sv =====
// Request and result channel interfaces of the identifier allocator.
// Depends on lfa_pkg for field widths.
`default_nettype none

interface lfa_req_if
  import lfa_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] req_type;
  logic [ID_W-1:0]  id;

  modport source (output valid, output req_type, output id, input ready);
  modport sink   (input valid, input req_type, input id, output ready);
endinterface

interface lfa_rsp_if
  import lfa_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [ID_W-1:0]   result_id;
  logic              is_taken;
  logic [ID_W-1:0]   largest_issued;
  logic              any_issued;

  modport source (output valid, output status, output result_id, output is_taken,
                  output largest_issued, output any_issued, input ready);
  modport sink   (input valid, input status, input result_id, input is_taken,
                  input largest_issued, input any_issued, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/lfa_ctrl.sv =====
// Controller of the identifier allocator: sequences accept, free-slot scan,
// bitmap update, largest-id scan and result load. Depends on lfa_pkg.
`default_nettype none

module lfa_ctrl
  import lfa_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      req_valid_i,
  output logic           req_ready_o,
  input  wire dp_stat_t  stat_i,
  output ctrl_cmd_t      cmd_o
);

  state_e state_q, state_d;

  // Advance the state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          state_d = stat_i.in_issue ? S_SCAN_FREE : S_APPLY;
        end
      end
      S_SCAN_FREE: begin
        if (stat_i.scan_last) begin
          state_d = S_APPLY;
        end
      end
      S_APPLY: begin
        state_d = S_SCAN_MAX;
      end
      S_SCAN_MAX: begin
        if (stat_i.scan_last) begin
          state_d = S_RESULT;
        end
      end
      S_RESULT: begin
        if (stat_i.rsp_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Commands
  always_comb begin
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        req_ready_o      = 1'b1;
        cmd_o.load_req   = req_valid_i;
        cmd_o.scan_clr   = 1'b1;
      end
      S_SCAN_FREE: begin
        cmd_o.scan_step  = 1'b1;
      end
      S_APPLY: begin
        cmd_o.apply      = 1'b1;
        cmd_o.scan_clr   = 1'b1;
      end
      S_SCAN_MAX: begin
        cmd_o.scan_step  = 1'b1;
      end
      S_RESULT: begin
        cmd_o.load_rsp   = stat_i.rsp_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/lfa_dp.sv =====
// Datapath of the identifier allocator: taken bitmap, chunked scan for the
// lowest free and highest taken slots, and the result register.
// Depends on lfa_pkg; driven by lfa_ctrl.
`default_nettype none

module lfa_dp
  import lfa_pkg::*;
#(
  parameter int ID_SLOTS = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [ID_W-1:0]   base_id_i,
  input  wire logic [CNT_W-1:0]  id_count_i,
  input  wire logic [REQ_W-1:0]  req_type_i,
  input  wire logic [ID_W-1:0]   id_i,
  input  wire ctrl_cmd_t         cmd_i,
  output dp_stat_t               stat_o,
  output logic                   rsp_valid_o,
  input  wire logic              rsp_ready_i,
  output logic [STAT_W-1:0]      rsp_status_o,
  output logic [ID_W-1:0]        rsp_result_id_o,
  output logic                   rsp_is_taken_o,
  output logic [ID_W-1:0]        rsp_largest_o,
  output logic                   rsp_any_o
);

  // Slots beyond the largest possible window are never reachable
  localparam int SLOT_N  = (ID_SLOTS < MAX_WIN) ? ID_SLOTS : MAX_WIN;
  localparam int SLOT_IW = (SLOT_N > 1) ? $clog2(SLOT_N) : 1;
  localparam int NCHUNK  = (SLOT_N + LANE_W - 1) / LANE_W;
  localparam int CHK_IW  = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int PAD_W   = NCHUNK * LANE_W;

  logic [SLOT_N-1:0] bitmap_q, bitmap_d;
  logic [REQ_W-1:0]  req_type_q;
  logic [ID_W-1:0]   id_q;
  logic [CHK_IW-1:0] chunk_q;
  logic              free_found_q, hi_any_q, lo_any_q;
  logic [CNT_W-1:0]  free_idx_q, hi_idx_q, lo_idx_q;
  status_e           st_q, st_d;
  logic [ID_W-1:0]   rid_q, rid_d;
  logic              tk_q, tk_d;
  logic              rsp_valid_q;
  status_e           rsp_status_q;
  logic [ID_W-1:0]   rsp_rid_q, rsp_largest_q;
  logic              rsp_tk_q, rsp_any_q;

  logic [CNT_W-1:0]  win;
  logic              has_wrap;
  logic [CNT_W-1:0]  wrap_lim;
  logic [ID_W-1:0]   off;
  logic              in_win;
  logic              off_bit;
  logic [CNT_W-1:0]  last_chk;
  logic [PAD_W-1:0]  map_pad;
  logic [LANE_W-1:0] chunk_bits;
  logic [CNT_W-1:0]  k_base;
  logic [LANE_W-1:0] free_m, taken_m, lo_m;
  logic              free_any, taken_any, lo_any;
  logic [LANE_IW-1:0] free_pos, taken_pos, lo_pos;
  logic [ID_W-1:0]   largest;

  // Window size, wrap point and request offset
  assign win      = (id_count_i < CNT_W'(SLOT_N)) ? id_count_i : CNT_W'(SLOT_N);
  assign has_wrap = (&base_id_i[ID_W-1:CNT_W]) && (base_id_i[CNT_W-1:0] != '0);
  assign wrap_lim = CNT_W'(0) - base_id_i[CNT_W-1:0];
  assign off      = id_q - base_id_i;
  assign in_win   = (off[ID_W-1:CNT_W] == '0) && (off[CNT_W-1:0] < win);
  assign off_bit  = in_win ? bitmap_q[off[SLOT_IW-1:0]] : 1'b0;
  assign last_chk = (win == '0) ? '0 : ((win - CNT_W'(1)) >> LANE_IW);

  // Pick the chunk under scan
  always_comb begin
    map_pad = '0;
    map_pad[SLOT_N-1:0] = bitmap_q;
  end
  assign chunk_bits = map_pad[chunk_q*LANE_W +: LANE_W];
  assign k_base     = CNT_W'(chunk_q) << LANE_IW;

  // Classify each lane of the chunk
  always_comb begin
    logic [CNT_W-1:0] k;
    for (int j = 0; j < LANE_W; j++) begin
      k          = k_base + CNT_W'(j);
      free_m[j]  = !chunk_bits[j] && (k < win);
      taken_m[j] = chunk_bits[j] && (k < win);
      lo_m[j]    = chunk_bits[j] && (k < win) && (!has_wrap || (k < wrap_lim));
    end
  end

  // Lowest free lane
  always_comb begin
    free_any = 1'b0;
    free_pos = '0;
    for (int j = LANE_W - 1; j >= 0; j--) begin
      if (free_m[j]) begin
        free_any = 1'b1;
        free_pos = LANE_IW'(j);
      end
    end
  end

  // Highest taken lanes, overall and below the wrap point
  always_comb begin
    taken_any = 1'b0;
    taken_pos = '0;
    lo_any    = 1'b0;
    lo_pos    = '0;
    for (int j = 0; j < LANE_W; j++) begin
      if (taken_m[j]) begin
        taken_any = 1'b1;
        taken_pos = LANE_IW'(j);
      end
      if (lo_m[j]) begin
        lo_any = 1'b1;
        lo_pos = LANE_IW'(j);
      end
    end
  end

  // Scan accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_q      <= '0;
      free_found_q <= 1'b0;
      hi_any_q     <= 1'b0;
      lo_any_q     <= 1'b0;
    end else if (cmd_i.scan_clr) begin
      chunk_q      <= '0;
      free_found_q <= 1'b0;
      hi_any_q     <= 1'b0;
      lo_any_q     <= 1'b0;
    end else if (cmd_i.scan_step) begin
      chunk_q <= chunk_q + CHK_IW'(1);
      if (!free_found_q && free_any) begin
        free_found_q <= 1'b1;
      end
      if (taken_any) begin
        hi_any_q <= 1'b1;
      end
      if (lo_any) begin
        lo_any_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_step) begin
      if (!free_found_q && free_any) begin
        free_idx_q <= k_base + CNT_W'(free_pos);
      end
      if (taken_any) begin
        hi_idx_q <= k_base + CNT_W'(taken_pos);
      end
      if (lo_any) begin
        lo_idx_q <= k_base + CNT_W'(lo_pos);
      end
    end
  end

  // Capture the request
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_type_q <= req_type_i;
      id_q       <= id_i;
    end
  end

  // Decide the outcome and the bitmap change
  always_comb begin
    bitmap_d = bitmap_q;
    st_d     = ST_FAIL;
    rid_d    = id_q;
    tk_d     = 1'b0;
    case (req_type_e'(req_type_q))
      REQ_ISSUE: begin
        if (free_found_q) begin
          bitmap_d[free_idx_q[SLOT_IW-1:0]] = 1'b1;
          st_d  = ST_OK;
          rid_d = base_id_i + ID_W'(free_idx_q);
        end
      end
      REQ_FREE: begin
        if (!in_win) begin
          st_d = ST_RANGE;
        end else if (off_bit) begin
          bitmap_d[off[SLOT_IW-1:0]] = 1'b0;
          st_d = ST_OK;
        end
      end
      REQ_QUERY: begin
        if (!in_win) begin
          st_d = ST_RANGE;
        end else begin
          st_d = ST_OK;
          tk_d = off_bit;
        end
      end
      default: begin
        st_d = ST_FAIL;
      end
    endcase
  end

  // Update the bitmap
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bitmap_q <= '0;
    end else if (cmd_i.apply) begin
      bitmap_q <= bitmap_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.apply) begin
      st_q  <= st_d;
      rid_q <= rid_d;
      tk_q  <= tk_d;
    end
  end

  // Largest issued value: prefer slots that do not wrap past the top
  always_comb begin
    if (lo_any_q) begin
      largest = base_id_i + ID_W'(lo_idx_q);
    end else if (hi_any_q) begin
      largest = base_id_i + ID_W'(hi_idx_q);
    end else begin
      largest = '0;
    end
  end

  // Result register: load when empty or draining, drop on take
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (cmd_i.load_rsp) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_rsp) begin
      rsp_status_q  <= st_q;
      rsp_rid_q     <= rid_q;
      rsp_tk_q      <= tk_q;
      rsp_largest_q <= largest;
      rsp_any_q     <= hi_any_q;
    end
  end

  assign stat_o.in_issue  = (req_type_i == REQ_ISSUE);
  assign stat_o.scan_last = (CNT_W'(chunk_q) == last_chk);
  assign stat_o.rsp_free  = !rsp_valid_q || rsp_ready_i;

  assign rsp_valid_o     = rsp_valid_q;
  assign rsp_status_o    = rsp_status_q;
  assign rsp_result_id_o = rsp_rid_q;
  assign rsp_is_taken_o  = rsp_tk_q;
  assign rsp_largest_o   = rsp_largest_q;
  assign rsp_any_o       = rsp_any_q;

endmodule

`default_nettype wire

// ===== rtl/core/lowest_free_id_allocator.sv =====
// Lowest-free-first identifier allocator, top level: APB register block,
// controller and datapath. Depends on lfa_pkg, lfa_if, lfa_ctrl, lfa_dp.
//
// Usage: requests arrive on req_i (valid/ready); req_type selects issue,
// free or query, and id names the identifier for free and query. Each
// request yields one result on rsp_o (status, result_id, is_taken,
// largest_issued, any_issued). base_id (address 0) and id_count (address 4)
// are written over the APB port; the user must write them only while no
// request is in flight, as the block itself does not enforce it.
// An issue runs a scan for the lowest free slot, then the bitmap update,
// then a scan for the largest issued id; a free or query skips the first
// scan. Each scan walks the window in chunks of 32 flags. The next
// request is taken in the cycle after the result is registered; no new
// request is accepted while one is in progress.
// The result sits in an output register; a stalled receiver holds it while
// the next request is accepted and processed, and that request waits in
// its final state until the register drains.
// Reset clears every taken flag, sets base_id to 0 and id_count to 64.
`default_nettype none

module lowest_free_id_allocator
  import lfa_pkg::*;
#(
  parameter int ID_SLOTS = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  lfa_req_if.sink                req_i,
  lfa_rsp_if.source              rsp_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready
);

  logic [ID_W-1:0]  base_id_q;
  logic [CNT_W-1:0] id_count_q;
  logic             cfg_wr;
  ctrl_cmd_t        cmd;
  dp_stat_t         stat;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_id_q  <= '0;
      id_count_q <= CNT_W'(64);
    end else if (cfg_wr) begin
      if (paddr[2] == REG_BASE_ID) begin
        base_id_q <= pwdata[ID_W-1:0];
      end else begin
        id_count_q <= pwdata[CNT_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_ID_COUNT) ? DATA_W'(id_count_q) : DATA_W'(base_id_q);

  lfa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  lfa_dp #(
    .ID_SLOTS (ID_SLOTS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .base_id_i       (base_id_q),
    .id_count_i      (id_count_q),
    .req_type_i      (req_i.req_type),
    .id_i            (req_i.id),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .rsp_valid_o     (rsp_o.valid),
    .rsp_ready_i     (rsp_o.ready),
    .rsp_status_o    (rsp_o.status),
    .rsp_result_id_o (rsp_o.result_id),
    .rsp_is_taken_o  (rsp_o.is_taken),
    .rsp_largest_o   (rsp_o.largest_issued),
    .rsp_any_o       (rsp_o.any_issued)
  );

endmodule

`default_nettype wire
